// ===== hdl/manchester_sample_decoder_assert.svh =====
// Assertion macros for the Manchester sample decoder.
// Each macro takes a label, clock, active-low reset, antecedent and consequent.
`ifndef MANCHESTER_SAMPLE_DECODER_ASSERT_SVH
`define MANCHESTER_SAMPLE_DECODER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication.
`define MSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("msd assertion failed");

// Next-cycle implication.
`define MSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("msd assertion failed");

`else

`define MSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/msd_pkg.sv =====
package msd_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CONFIGURED  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd2;

	localparam int BITS_PER_BYTE = 8;
	localparam logic [2:0] LAST_BIT = 3'(BITS_PER_BYTE - 1);
	localparam logic [7:0] SYMBOL_SIZE_RESET = 8'd1;

	// decoder state apart from the previous sample
	typedef struct packed {
		logic [7:0] sample_counter;
		logic       current_bit;
		logic [2:0] bit_counter;
		logic [7:0] shift_byte;
		logic [7:0] held_byte;
	} dec_state_t;

	// one result item
	typedef struct packed {
		logic       symbol_end;
		logic       decoded_bit;
		logic       byte_ready;
		logic [7:0] data_byte;
	} result_t;

endpackage

// ===== hdl/manchester_sample_decoder.sv =====
// Manchester decoder for threshold-sampled ADC data. Each accepted sample
// yields exactly one result item: symbol_end marks the sample that closed a
// symbol (every symbol_size samples), byte_ready the one that completed an
// eighth bit, decoded_bit is the bit after this sample, and data_byte the last
// delivered byte (MSB first). A rise through threshold sets the bit to 0, a
// fall sets it to 1; a sample equal to threshold is not a crossing. While
// configured is 0 samples still produce items, but nothing in the decoder
// moves and symbol_end and byte_ready stay 0. Throughput is one sample per
// clock while result_stall is low, set by the single decode pass between the
// input register and the result register. A sample is held in the input
// register, then its result in the result register until it is taken.
// Configuration writes take effect at the next edge and must be made with the
// block idle. Decoder state is not cleared by configuration writes.
`include "manchester_sample_decoder_assert.svh"

module manchester_sample_decoder #(
	parameter int SAMPLE_BITS = 12,
	localparam int CFG_W = (SAMPLE_BITS > 8) ? SAMPLE_BITS : 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic [msd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]                cfg_data,
	// sample channel
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  logic [SAMPLE_BITS-1:0]          sample,
	// result channel
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic                            symbol_end,
	output logic                            decoded_bit,
	output logic                            byte_ready,
	output logic [7:0]                      data_byte
);

	// config registers
	logic                   configured_q;
	logic [7:0]             symbol_size_q;
	logic [SAMPLE_BITS-1:0] threshold_q;

	// input stage
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;

	// decoder state
	msd_pkg::dec_state_t    state_q;
	msd_pkg::dec_state_t    state_nxt;
	logic [SAMPLE_BITS-1:0] prev_q;

	// result stage
	msd_pkg::result_t       result_q;
	msd_pkg::result_t       result_nxt;
	logic                   result_valid_q;

	logic                   accept;
	logic                   advance;
	logic                   out_free;

	// result register frees when empty or being taken this cycle
	assign out_free     = !result_valid_q || !result_stall;
	assign advance      = valid_s1 && out_free;
	assign sample_stall = valid_s1 && !out_free;
	assign accept       = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			configured_q  <= 1'b0;
			symbol_size_q <= msd_pkg::SYMBOL_SIZE_RESET;
			threshold_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				msd_pkg::CFG_CONFIGURED:  configured_q  <= cfg_data[0];
				msd_pkg::CFG_SYMBOL_SIZE: symbol_size_q <= cfg_data[7:0];
				msd_pkg::CFG_THRESHOLD:   threshold_q   <= cfg_data[SAMPLE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
		end
	end

	msd_decode #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_decode (
		.configured  (configured_q),
		.symbol_size (symbol_size_q),
		.threshold   (threshold_q),
		.sample      (sample_s1),
		.prev_sample (prev_q),
		.state       (state_q),
		.state_next  (state_nxt),
		.result      (result_nxt)
	);

	// state moves only when the item leaves the input stage;
	// the previous sample is held while unconfigured
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			prev_q  <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
			if (configured_q) begin
				prev_q <= sample_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign symbol_end   = result_q.symbol_end;
	assign decoded_bit  = result_q.decoded_bit;
	assign byte_ready   = result_q.byte_ready;
	assign data_byte    = result_q.data_byte;

	// a delivered byte always closes a symbol
	`MSD_ASSERT_IMP(a_byte_has_sym, clk, arst_n, result_valid_q && result_q.byte_ready, result_q.symbol_end)
	// input stage only backs up when it holds an item
	`MSD_ASSERT_IMP(a_stall_needs_item, clk, arst_n, sample_stall, valid_s1)
	// unconfigured items never close a symbol
	`MSD_ASSERT_NXT(a_idle_no_sym, clk, arst_n, advance && !configured_q, !result_q.symbol_end && !result_q.byte_ready)
	// byte delivery clears the assembly state
	`MSD_ASSERT_NXT(a_byte_clears, clk, arst_n, advance && result_nxt.byte_ready, state_q.bit_counter == 3'd0 && state_q.shift_byte == 8'd0)

endmodule

// ===== hdl/msd_decode.sv =====
// Per-sample decode step: crossing detect, symbol count, byte assembly.
module msd_decode #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                      configured,
	input  logic [7:0]                symbol_size,
	input  logic [SAMPLE_BITS-1:0]    threshold,
	input  logic [SAMPLE_BITS-1:0]    sample,
	input  logic [SAMPLE_BITS-1:0]    prev_sample,
	input  msd_pkg::dec_state_t       state,
	output msd_pkg::dec_state_t       state_next,
	output msd_pkg::result_t          result
);

	logic       rising;
	logic       falling;
	logic       bit_val;
	logic [7:0] cnt_inc;
	logic       sym_done;
	logic [7:0] shifted;

	// strict compares: a sample equal to threshold is no crossing
	assign rising  = (sample > threshold) && (prev_sample < threshold);
	assign falling = (sample < threshold) && (prev_sample > threshold);
	assign bit_val = rising ? 1'b0 : (falling ? 1'b1 : state.current_bit);

	assign cnt_inc  = state.sample_counter + 8'd1;
	assign sym_done = (cnt_inc == symbol_size);
	assign shifted  = {state.shift_byte[6:0], bit_val};

	always_comb begin
		state_next = state;
		result.symbol_end  = 1'b0;
		result.byte_ready  = 1'b0;
		result.decoded_bit = state.current_bit;
		result.data_byte   = state.held_byte;
		if (configured) begin
			state_next.current_bit = bit_val;
			if (sym_done) begin
				state_next.sample_counter = '0;
				result.symbol_end = 1'b1;
				if (state.bit_counter == msd_pkg::LAST_BIT) begin
					state_next.held_byte   = shifted;
					state_next.shift_byte  = '0;
					state_next.bit_counter = '0;
					result.byte_ready      = 1'b1;
				end else begin
					state_next.shift_byte  = shifted;
					state_next.bit_counter = state.bit_counter + 3'd1;
				end
			end else begin
				state_next.sample_counter = cnt_inc;
			end
			result.decoded_bit = bit_val;
			result.data_byte   = state_next.held_byte;
		end
	end

endmodule
